/* hw/rtl/lcdvcr_pkg.sv */
// Shared types and constants of the LCD video control register bank.
// Command and status codes, write masks, dither patterns, frame timing scale.
// No dependencies.
package lcdvcr_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_SHADE = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BADADDR = 3'd1,
        ST_WONLY   = 3'd2,
        ST_RESV    = 3'd3,
        ST_MODE    = 3'd4,
        ST_PATTERN = 3'd5
    } status_t;

    localparam int unsigned NUM_WORDS = 14;

    localparam logic [31:0] CTL1_WRITABLE  = 32'h003F_FFFF;
    localparam logic [31:0] CTL2_RESERVED  = 32'h0020_0C00;
    localparam logic [31:0] CTL4_FRAMEMASK = 32'h00F0_0000;
    localparam logic [31:0] NIBBLE_RES     = 32'h0000_000F;
    localparam logic [31:0] CTL7_RESERVED  = 32'hFFFF_0000;
    localparam logic [31:0] CTL8_RESERVED  = 32'hFFFF_F000;
    localparam logic [31:0] PAT20_RESERVED = 32'hFFF0_0000;
    localparam logic [31:0] PAT28_RESERVED = 32'hF000_0000;

    localparam logic [31:0] PAT_CTL8  = 32'h0000_07DA;
    localparam logic [31:0] PAT_15_1  = 32'h7DBE_A5A5;
    localparam logic [31:0] PAT_4_5   = 32'h0007_DFBE;
    localparam logic [31:0] PAT_3_4   = 32'h0007_A5AD;
    localparam logic [31:0] PAT_2_3   = 32'h0FBF_DFE7;
    localparam logic [31:0] PAT_4_7   = 32'h07B5_ADEF;
    localparam logic [31:0] PAT_3_5   = 32'h0B9D_C663;

    // Frame period = P * 1e9 / 18432000 = P * 15625 / 288, with
    // P = (baud+1)*(rate+1)*(lines+1). 288 = 32 * 9; divide by 9 by reciprocal.
    localparam logic [13:0] FRAME_SCALE = 14'd15625;
    // ceil(2^25 / 9), exact for quotients of values below 2^21
    localparam logic [21:0] RECIP_A     = 22'd3728271;
    // ceil(2^22 / 9), exact for quotients of values below 2^18
    localparam logic [18:0] RECIP_B     = 19'd466034;

endpackage

/* hw/rtl/lcd_video_control_registers_core.sv */
// A command accepted while idle steps the sequencer through S_RATE, S_LINES,
// S_QUOT, S_SPLIT, S_REM, S_FRAC and S_DONE, with busy high meanwhile; done
// rises with the registered result word. A new command is taken only in idle,
// as the shared multiplier steps through the frame period product and the two
// reciprocal divisions. The receiver cannot stall: done lasts one cycle.
// Asynchronous reset clears all fourteen control words; the sequencer goes idle.
// Depends on lcdvcr_pkg.
module lcd_video_control_registers_core
    import lcdvcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [3:0]  reg_index,
    input  logic [31:0] write_data,
    input  logic [3:0]  raw_pixel,
    output logic        done,
    output logic [31:0] read_data,
    output logic [2:0]  status,
    output logic [3:0]  shade,
    output logic [30:0] frame_period_ns,
    output logic        video_enabled,
    output logic        enable_rise,
    output logic [12:0] display_width,
    output logic [10:0] display_height,
    output logic [3:0]  bits_per_pixel
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_LINES,
        S_QUOT,
        S_SPLIT,
        S_REM,
        S_FRAC,
        S_DONE
    } state_t;

    state_t       state_reg, state_next;
    logic [31:0]  words_reg [NUM_WORDS];
    logic [31:0]  words_next [NUM_WORDS];
    logic [42:0]  prod_reg, prod_next;
    logic [25:0]  p_reg, p_next;
    logic [8:0]   r_reg, r_next;
    logic [30:0]  hi_reg, hi_next;
    logic         done_reg, done_next;
    logic [31:0]  rd_reg, rd_next;
    status_t      status_reg, status_next;
    logic [3:0]   shade_reg, shade_next;
    logic         rise_reg, rise_next;
    logic [30:0]  period_reg, period_next;
    logic         enabled_reg, enabled_next;
    logic [12:0]  width_reg, width_next;
    logic [10:0]  height_reg, height_next;
    logic [3:0]   bpp_reg, bpp_next;

    logic [20:0]  mul_a;
    logic [21:0]  mul_b;
    logic [16:0]  quot;

    // fields of the stored control words
    logic [4:0]   baud;
    logic [9:0]   rate;
    logic [9:0]   lines;
    logic [8:0]   horz;
    logic [1:0]   bitsel;

    assign baud   = words_reg[0][20:16];
    assign bitsel = words_reg[0][7:6];
    assign rate   = words_reg[1][31:22];
    assign horz   = words_reg[1][20:12];
    assign lines  = words_reg[1][9:0];
    assign quot   = prod_reg[41:25];

    assign busy = (state_reg != S_IDLE);

    // shared multiplier
    assign prod_next = 43'(mul_a) * 43'(mul_b);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_RATE:
            begin
                mul_a = 21'({1'b0, baud} + 6'd1);
                mul_b = 22'({1'b0, rate} + 11'd1);
            end
            S_LINES:
            begin
                mul_a = 21'(prod_reg[15:0]);
                mul_b = 22'({1'b0, lines} + 11'd1);
            end
            S_QUOT:
            begin
                mul_a = prod_reg[25:5];
                mul_b = RECIP_A;
            end
            S_SPLIT:
            begin
                mul_a = 21'(quot);
                mul_b = 22'(FRAME_SCALE);
            end
            S_REM:
            begin
                mul_a = 21'(r_reg);
                mul_b = 22'(FRAME_SCALE);
            end
            S_FRAC:
            begin
                mul_a = 21'(prod_reg[22:5]);
                mul_b = 22'(RECIP_B);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        logic [3:0]  duty;
        logic [31:0] v;
        logic [10:0] horz_p1;

        state_next   = state_reg;
        words_next   = words_reg;
        p_next       = p_reg;
        r_next       = r_reg;
        hi_next      = hi_reg;
        done_next    = 1'b0;
        rd_next      = rd_reg;
        status_next  = status_reg;
        shade_next   = shade_reg;
        rise_next    = rise_reg;
        period_next  = period_reg;
        enabled_next = enabled_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        bpp_next     = bpp_reg;
        duty         = '0;
        v            = write_data;
        horz_p1      = 11'({1'b0, horz} + 10'd1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next  = S_RATE;
                    rd_next     = '0;
                    status_next = ST_OK;
                    shade_next  = '0;
                    rise_next   = 1'b0;
                    unique case (cmd_t'(command))
                        CMD_READ:
                        begin
                            if (reg_index >= 4'(NUM_WORDS))
                                status_next = ST_BADADDR;
                            else if (reg_index == 4'd0)
                                rd_next = words_reg[0];
                            else if (reg_index == 4'd3)
                                rd_next = words_reg[3];
                            else
                                status_next = ST_WONLY;
                        end
                        CMD_WRITE:
                        begin
                            unique case (reg_index)
                                4'd0:
                                begin
                                    if (v[5] || v[7:6] == 2'b11)
                                        status_next = ST_MODE;
                                    else
                                    begin
                                        words_next[0] = v & CTL1_WRITABLE;
                                        rise_next     = !words_reg[0][0] && v[0];
                                    end
                                end
                                4'd1:
                                begin
                                    if ((v & CTL2_RESERVED) != '0)
                                        status_next = ST_RESV;
                                    else
                                        words_next[1] = v;
                                end
                                4'd2:
                                begin
                                    if ((v & NIBBLE_RES) != '0)
                                        status_next = ST_RESV;
                                    else
                                        words_next[2] = v;
                                end
                                4'd3:
                                begin
                                    if ((v & NIBBLE_RES) != '0)
                                        status_next = ST_RESV;
                                    else if ((v & CTL4_FRAMEMASK) != '0)
                                        status_next = ST_MODE;
                                    else
                                        words_next[3] = v;
                                end
                                4'd4, 4'd5:
                                begin
                                    words_next[reg_index] = v;
                                end
                                4'd6:
                                begin
                                    if ((v & CTL7_RESERVED) != '0)
                                        status_next = ST_RESV;
                                    else
                                        words_next[6] = v;
                                end
                                4'd7:
                                begin
                                    if ((v & CTL8_RESERVED) != '0)
                                        status_next = ST_RESV;
                                    else if (v != PAT_CTL8)
                                        status_next = ST_PATTERN;
                                    else
                                        words_next[7] = v;
                                end
                                4'd8:
                                begin
                                    if (v != PAT_15_1)
                                        status_next = ST_PATTERN;
                                    else
                                        words_next[8] = v;
                                end
                                4'd9:
                                begin
                                    if ((v & PAT20_RESERVED) != '0)
                                        status_next = ST_RESV;
                                    else if (v != PAT_4_5)
                                        status_next = ST_PATTERN;
                                    else
                                        words_next[9] = v;
                                end
                                4'd10:
                                begin
                                    if ((v & PAT20_RESERVED) != '0)
                                        status_next = ST_RESV;
                                    else if (v != PAT_3_4)
                                        status_next = ST_PATTERN;
                                    else
                                        words_next[10] = v;
                                end
                                4'd11:
                                begin
                                    if ((v & PAT28_RESERVED) != '0)
                                        status_next = ST_RESV;
                                    else if (v != PAT_2_3)
                                        status_next = ST_PATTERN;
                                    else
                                        words_next[11] = v;
                                end
                                4'd12:
                                begin
                                    if ((v & PAT28_RESERVED) != '0)
                                        status_next = ST_RESV;
                                    else if (v != PAT_4_7)
                                        status_next = ST_PATTERN;
                                    else
                                        words_next[12] = v;
                                end
                                4'd13:
                                begin
                                    if ((v & PAT28_RESERVED) != '0)
                                        status_next = ST_RESV;
                                    else if (v != PAT_3_5)
                                        status_next = ST_PATTERN;
                                    else
                                        words_next[13] = v;
                                end
                                default:
                                begin
                                    status_next = ST_BADADDR;
                                end
                            endcase
                        end
                        CMD_SHADE:
                        begin
                            case (bitsel)
                                2'd1:    duty = words_reg[6][{raw_pixel[1:0], 2'b00} +: 4];
                                2'd0:    duty = (raw_pixel != '0) ? 4'hF : 4'h0;
                                default: duty = raw_pixel;
                            endcase
                            // invert flag cancels the final flip
                            shade_next = words_reg[0][2] ? duty : ~duty;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_RATE:
            begin
                state_next = S_LINES;
            end
            S_LINES:
            begin
                state_next = S_QUOT;
            end
            S_QUOT:
            begin
                // hold P, the full baud, rate and lines product
                p_next     = prod_reg[25:0];
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                // remainder of P by 288
                r_next     = 9'(p_reg - ({1'b0, quot, 8'b0} + {4'b0, quot, 5'b0}));
                state_next = S_REM;
            end
            S_REM:
            begin
                hi_next    = prod_reg[30:0];
                state_next = S_FRAC;
            end
            S_FRAC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                period_next  = hi_reg + 31'(prod_reg[35:22]);
                enabled_next = words_reg[0][0];
                width_next   = words_reg[0][4] ? 13'({horz_p1, 3'b000})
                                               : 13'({horz_p1, 2'b00});
                height_next  = 11'({1'b0, lines} + 11'd1);
                bpp_next     = 4'(4'd1 << bitsel);
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                words_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            words_reg <= words_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        p_reg       <= p_next;
        r_reg       <= r_next;
        hi_reg      <= hi_next;
        rd_reg      <= rd_next;
        status_reg  <= status_next;
        shade_reg   <= shade_next;
        rise_reg    <= rise_next;
        period_reg  <= period_next;
        enabled_reg <= enabled_next;
        width_reg   <= width_next;
        height_reg  <= height_next;
        bpp_reg     <= bpp_next;
    end

    assign done            = done_reg;
    assign read_data       = rd_reg;
    assign status          = status_reg;
    assign shade           = shade_reg;
    assign frame_period_ns = period_reg;
    assign video_enabled   = enabled_reg;
    assign enable_rise     = rise_reg;
    assign display_width   = width_reg;
    assign display_height  = height_reg;
    assign bits_per_pixel  = bpp_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_RATE))
        else $error("accepted word did not start the sequence");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result shown while sequencer busy");

    a_rise_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rise_reg) |-> enabled_reg)
        else $error("enable rise reported with video disabled");

    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_OK) |-> (rd_reg == '0 && !rise_reg))
        else $error("rejected command carries data");

    a_word0_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (words_reg[0][5] == 1'b0) && (words_reg[0][7:6] != 2'b11))
        else $error("unsupported mode stored in control word 0");

endmodule
